FILE: hdl/tick_task_scheduler_table_assert.svh
// Assertion macros for the tick task scheduler table.
`ifndef TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tick_task_scheduler_table: assertion failed");
`define TTST_ASSERT_IMPL(lbl, ante, cons) `TTST_ASSERT(lbl, (ante) |-> (cons))
`define TTST_ASSERT_NEXT(lbl, ante, cons) `TTST_ASSERT(lbl, (ante) |=> (cons))
`else
`define TTST_ASSERT(lbl, prop)
`define TTST_ASSERT_IMPL(lbl, ante, cons)
`define TTST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/ttst_pkg.sv
// Shared types and constants of the tick task scheduler table.
package ttst_pkg;

  localparam int TASKS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int STEP_W      = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = 4;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DELETE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_RUN    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  task_handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } slot_t;

  // Controls from the sequencer to the slot update unit.
  typedef struct packed {
    op_e         op;
    logic [7:0]  task_handle;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic        del_hit;
    logic        add_open;
    logic        disp_open;
  } head_ctl_t;

  // Status back from the slot update unit.
  typedef struct packed {
    logic claim;
    logic run;
  } head_res_t;

endpackage

FILE: hdl/ttst_if.sv
// Valid/ready channel interfaces for scheduler requests and replies.
interface ttst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  task_handle;
  logic [15:0] first_delay;
  logic [15:0] repeat_period;
  logic [2:0]  slot_index;

  modport source (
    output valid, operation, task_handle, first_delay, repeat_period, slot_index,
    input  ready
  );
  modport sink (
    input  valid, operation, task_handle, first_delay, repeat_period, slot_index,
    output ready
  );
endinterface

interface ttst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [3:0] slot;
  logic [7:0] run_handle;
  logic       last;

  modport source (
    output valid, reply_kind, slot, run_handle, last,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, slot, run_handle, last,
    output ready
  );
endinterface

FILE: hdl/ttst_cell.sv
// One slot cell of the rotating slot ring.
module ttst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  ttst_pkg::slot_t slot_i,
  output ttst_pkg::slot_t slot_o
);

  ttst_pkg::slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

FILE: hdl/ttst_head.sv
// Slot update unit: applies the current operation to the slot leaving the ring head.
module ttst_head (
  input  ttst_pkg::slot_t     slot_i,
  input  ttst_pkg::head_ctl_t ctl_i,
  output ttst_pkg::slot_t     slot_o,
  output ttst_pkg::head_res_t res_o
);

  always_comb begin
    slot_o = slot_i;
    res_o  = '0;
    case (ctl_i.op)
      ttst_pkg::OP_TICK: begin
        if (slot_i.valid) begin
          if (slot_i.delay == '0) begin
            if (slot_i.pending != 8'hFF) begin
              slot_o.pending = slot_i.pending + 8'd1;
            end
            if (slot_i.period != '0) begin
              slot_o.delay = slot_i.period - 16'd1;
            end
          end else begin
            slot_o.delay = slot_i.delay - 16'd1;
          end
        end
      end
      ttst_pkg::OP_ADD: begin
        if (ctl_i.add_open && !slot_i.valid) begin
          slot_o.valid       = 1'b1;
          slot_o.task_handle = ctl_i.task_handle;
          slot_o.delay       = ctl_i.first_delay;
          slot_o.period      = ctl_i.repeat_period;
          slot_o.pending     = '0;
          res_o.claim        = 1'b1;
        end
      end
      ttst_pkg::OP_DELETE: begin
        if (ctl_i.del_hit) begin
          slot_o = '0;
        end
      end
      default: begin
        if (ctl_i.disp_open && slot_i.valid && slot_i.pending != '0) begin
          res_o.run      = 1'b1;
          slot_o.pending = slot_i.pending - 8'd1;
          // one-shot task leaves the table once dispatched
          if (slot_i.period == '0) begin
            slot_o = '0;
          end
        end
      end
    endcase
  end

endmodule

FILE: hdl/tick_task_scheduler_table.sv
// Every item walks the slot ring once, one slot per cycle through the shared update unit
// while the ring is not frozen; add, delete and nothing-ready replies come from a reply
// state after the walk. Requests are accepted only in the idle state, so no new request is
// taken before the last one is through; a dispatch result waiting on the output register
// freezes the ring until it is taken.
// Reset clears all slots and the output register at once; no clearing pass.
module tick_task_scheduler_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttst_in_if.sink    in_i,
  ttst_out_if.source out_o
);

`include "tick_task_scheduler_table_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REPLY
  } state_e;

  state_e                        state_q;
  logic [ttst_pkg::STEP_W-1:0]   step_q;
  ttst_pkg::op_e                 op_q;
  logic [7:0]                    handle_q;
  logic [15:0]                   delay_q;
  logic [15:0]                   period_q;
  logic [2:0]                    index_q;
  logic                          found_q;
  logic [ttst_pkg::STEP_W-1:0]   found_idx_q;
  logic [ttst_pkg::CNT_W-1:0]    cnt_q;
  logic [ttst_pkg::TASKS-1:0]    due_q;

  logic                          out_valid_q;
  ttst_pkg::kind_e               kind_q;
  logic [ttst_pkg::SLOT_W-1:0]   slot_q;
  logic [7:0]                    run_handle_q;
  logic                          last_q;

  ttst_pkg::slot_t               slots [ttst_pkg::TASKS];
  ttst_pkg::slot_t               head_nxt;
  ttst_pkg::head_ctl_t           ctl;
  ttst_pkg::head_res_t           res;
  logic [ttst_pkg::TASKS-1:0]    due;
  logic                          can_emit;
  logic                          advance;
  logic                          shift_en;
  logic                          last_step;
  logic                          later_due;
  logic                          out_load;

  // ring: each cell takes its upper neighbor, the top cell takes the updated head slot
  for (genvar i = 0; i < ttst_pkg::TASKS; i++) begin : g_ring
    ttst_pkg::slot_t nxt;
    if (i == ttst_pkg::TASKS - 1) begin : g_top
      assign nxt = head_nxt;
    end else begin : g_mid
      assign nxt = slots[i+1];
    end
    ttst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_en),
      .slot_i (nxt),
      .slot_o (slots[i])
    );
    assign due[i] = slots[i].valid && (slots[i].pending != '0);
  end

  always_comb begin
    ctl.op            = op_q;
    ctl.task_handle   = handle_q;
    ctl.first_delay   = delay_q;
    ctl.repeat_period = period_q;
    ctl.del_hit       = (op_q == ttst_pkg::OP_DELETE) && (int'(index_q) == int'(step_q));
    ctl.add_open      = !found_q;
    ctl.disp_open     = cnt_q < ttst_pkg::CNT_W'(ttst_pkg::MAX_RESULTS);
  end

  ttst_head u_head (
    .slot_i(slots[0]),
    .ctl_i (ctl),
    .slot_o(head_nxt),
    .res_o (res)
  );

  always_comb begin
    can_emit  = !out_valid_q || out_o.ready;
    advance   = !res.run || can_emit;
    shift_en  = (state_q == ST_WALK) && advance;
    last_step = step_q == ttst_pkg::STEP_W'(ttst_pkg::TASKS - 1);
    // due mask is taken at accept; later slots are untouched until their turn
    later_due = ((due_q >> step_q) >> 1) != '0;
    out_load  = (shift_en && res.run) || ((state_q == ST_REPLY) && can_emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      op_q         <= ttst_pkg::OP_TICK;
      handle_q     <= '0;
      delay_q      <= '0;
      period_q     <= '0;
      index_q      <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      cnt_q        <= '0;
      due_q        <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= ttst_pkg::KIND_ADD;
      slot_q       <= '0;
      run_handle_q <= '0;
      last_q       <= 1'b0;
    end else begin
      if (out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q     <= ttst_pkg::op_e'(in_i.operation);
            handle_q <= in_i.task_handle;
            delay_q  <= in_i.first_delay;
            period_q <= in_i.repeat_period;
            index_q  <= in_i.slot_index;
            due_q    <= due;
            step_q   <= '0;
            found_q  <= 1'b0;
            cnt_q    <= '0;
            state_q  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (advance) begin
            step_q <= last_step ? '0 : step_q + ttst_pkg::STEP_W'(1);
            if (res.claim) begin
              found_q     <= 1'b1;
              found_idx_q <= step_q;
            end
            if (res.run) begin
              out_valid_q  <= 1'b1;
              kind_q       <= ttst_pkg::KIND_RUN;
              slot_q       <= ttst_pkg::SLOT_W'(step_q);
              run_handle_q <= slots[0].task_handle;
              last_q       <= !later_due ||
                              (cnt_q == ttst_pkg::CNT_W'(ttst_pkg::MAX_RESULTS - 1));
              cnt_q        <= cnt_q + ttst_pkg::CNT_W'(1);
            end
            if (last_step) begin
              case (op_q)
                ttst_pkg::OP_TICK: begin
                  state_q <= ST_IDLE;
                end
                ttst_pkg::OP_DISPATCH: begin
                  state_q <= (cnt_q == '0 && !res.run) ? ST_REPLY : ST_IDLE;
                end
                default: begin
                  state_q <= ST_REPLY;
                end
              endcase
            end
          end
        end
        ST_REPLY: begin
          if (can_emit) begin
            out_valid_q  <= 1'b1;
            run_handle_q <= '0;
            last_q       <= 1'b1;
            unique case (op_q)
              ttst_pkg::OP_ADD: begin
                kind_q <= ttst_pkg::KIND_ADD;
                slot_q <= found_q ? ttst_pkg::SLOT_W'(found_idx_q)
                                  : ttst_pkg::SLOT_W'(ttst_pkg::TASKS);
              end
              ttst_pkg::OP_DELETE: begin
                kind_q <= ttst_pkg::KIND_DELETE;
                slot_q <= ttst_pkg::SLOT_W'(index_q);
              end
              default: begin
                kind_q <= ttst_pkg::KIND_NONE;
                slot_q <= '0;
              end
            endcase
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready       = state_q == ST_IDLE;
  assign out_o.valid      = out_valid_q;
  assign out_o.reply_kind = kind_q;
  assign out_o.slot       = slot_q;
  assign out_o.run_handle = run_handle_q;
  assign out_o.last       = last_q;

  `TTST_ASSERT(a_step_bound, step_q <= ttst_pkg::STEP_W'(ttst_pkg::TASKS - 1))
  `TTST_ASSERT(a_cnt_bound, cnt_q <= ttst_pkg::CNT_W'(ttst_pkg::MAX_RESULTS))
  `TTST_ASSERT_IMPL(a_load_free, out_load, !out_valid_q || out_o.ready)
  `TTST_ASSERT_NEXT(a_accept_walk, in_i.valid && in_i.ready, state_q == ST_WALK && step_q == '0)

endmodule

FILE: tb/ttst_reply_checker.sv
// Reply checker for the scheduler table: predicts every reply from the observed requests.
module ttst_reply_checker
  import ttst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  task_handle_i,
  input  logic [15:0] first_delay_i,
  input  logic [15:0] repeat_period_i,
  input  logic [2:0]  slot_index_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [1:0]  reply_kind_i,
  input  logic [3:0]  slot_i,
  input  logic [7:0]  run_handle_i,
  input  logic        last_i,
  output int          owed_o,
  output int          errors_o
);

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        run_handle;
    logic              last;
  } reply_t;

  slot_t  task_tbl [TASKS];
  reply_t owed_q [$];
  int     err_cnt = 0;
  int     owed_cnt;

  assign owed_o   = owed_cnt;
  assign errors_o = err_cnt;

  task automatic report(input string msg);
    err_cnt++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  function automatic void owe(input kind_e kind, input int slot, input logic [7:0] hnd,
                              input logic last);
    reply_t r;
    r.kind       = kind;
    r.slot       = SLOT_W'(slot);
    r.run_handle = hnd;
    r.last       = last;
    owed_q.push_back(r);
  endfunction

  // Applies one accepted request to the table and queues the replies it owes.
  task automatic schedule_update(input op_e op, input logic [7:0] hnd,
                                 input logic [15:0] dly, input logic [15:0] prd,
                                 input logic [2:0] idx);
    int             free_slot;
    logic [TASKS-1:0] due;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < TASKS; i++) begin
          if (task_tbl[i].valid) begin
            if (task_tbl[i].delay == 16'd0) begin
              if (task_tbl[i].pending != 8'hFF) task_tbl[i].pending++;
              if (task_tbl[i].period != 16'd0) task_tbl[i].delay = task_tbl[i].period - 16'd1;
            end else begin
              task_tbl[i].delay--;
            end
          end
        end
      end
      OP_ADD: begin
        free_slot = TASKS;
        for (int i = TASKS - 1; i >= 0; i--)
          if (!task_tbl[i].valid) free_slot = i;
        if (free_slot < TASKS) task_tbl[free_slot] = '{1'b1, hnd, dly, prd, 8'd0};
        owe(KIND_ADD, free_slot, 8'd0, 1'b1);
      end
      OP_DELETE: begin
        if (int'(idx) < TASKS) task_tbl[idx] = '0;
        owe(KIND_DELETE, int'(idx), 8'd0, 1'b1);
      end
      default: begin
        // a run only touches its own slot, so the due set is fixed up front
        for (int i = 0; i < TASKS; i++)
          due[i] = task_tbl[i].valid && (task_tbl[i].pending != 8'd0);
        if (due == '0) begin
          owe(KIND_NONE, 0, 8'd0, 1'b1);
        end else begin
          for (int i = 0; i < TASKS; i++) begin
            if (due[i]) begin
              owe(KIND_RUN, i, task_tbl[i].task_handle, (due >> (i + 1)) == '0);
              task_tbl[i].pending--;
              if (task_tbl[i].period == 16'd0) task_tbl[i] = '0;
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    if (owed_q.size() == 0) begin
      report($sformatf("unexpected reply kind %0d slot %0d handle %0h last %0b",
                       reply_kind_i, slot_i, run_handle_i, last_i));
    end else begin
      want = owed_q.pop_front();
      if (reply_kind_i !== want.kind || slot_i !== want.slot ||
          run_handle_i !== want.run_handle || last_i !== want.last)
        report($sformatf("reply kind/slot/handle/last got %0d/%0d/%0h/%0b want %0d/%0d/%0h/%0b",
                         reply_kind_i, slot_i, run_handle_i, last_i,
                         want.kind, want.slot, want.run_handle, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASKS; i++) task_tbl[i] = '0;
      owed_q.delete();
      owed_cnt <= 0;
    end else begin
      if (req_valid_i && req_ready_i)
        schedule_update(op_e'(operation_i), task_handle_i, first_delay_i, repeat_period_i,
                        slot_index_i);
      if (rsp_valid_i && rsp_ready_i) check_reply();
      owed_cnt <= owed_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the scheduler table testbench: clock, reset, request stimulus, reply stalls, verdict.
module testbench;
  import ttst_pkg::*;

  typedef struct {
    op_e         op;
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [2:0]  idx;
  } sched_req_t;

  logic clk;
  logic rst_n;
  logic hold_req;
  int   tx_idle;
  int   rx_idle;
  int   owed;
  int   errors;

  ttst_in_if  req_ch ();
  ttst_out_if rsp_ch ();

  tick_task_scheduler_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  ttst_reply_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_ch.valid),
    .req_ready_i     (req_ch.ready),
    .operation_i     (req_ch.operation),
    .task_handle_i   (req_ch.task_handle),
    .first_delay_i   (req_ch.first_delay),
    .repeat_period_i (req_ch.repeat_period),
    .slot_index_i    (req_ch.slot_index),
    .rsp_valid_i     (rsp_ch.valid),
    .rsp_ready_i     (rsp_ch.ready),
    .reply_kind_i    (rsp_ch.reply_kind),
    .slot_i          (rsp_ch.slot),
    .run_handle_i    (rsp_ch.run_handle),
    .last_i          (rsp_ch.last),
    .owed_o          (owed),
    .errors_o        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic sched_req_t mk(input op_e op, input logic [7:0] hnd,
                                    input logic [15:0] dly, input logic [15:0] prd,
                                    input logic [2:0] idx);
    sched_req_t r;
    r.op     = op;
    r.handle = hnd;
    r.delay  = dly;
    r.period = prd;
    r.idx    = idx;
    return r;
  endfunction

  // Mostly short delays and periods so tasks come due; some full-range values.
  function automatic sched_req_t rand_req();
    sched_req_t r;
    int         w;
    w = $urandom_range(99);
    if (w < 40)      r.op = OP_TICK;
    else if (w < 62) r.op = OP_ADD;
    else if (w < 74) r.op = OP_DELETE;
    else             r.op = OP_DISPATCH;
    r.handle = 8'($urandom_range(255));
    r.delay  = ($urandom_range(99) < 85) ? 16'($urandom_range(4)) : 16'($urandom);
    r.period = ($urandom_range(99) < 85) ? 16'($urandom_range(5)) : 16'($urandom);
    r.idx    = 3'($urandom_range(7));
    return r;
  endfunction

  task automatic send(input sched_req_t r);
    while ($urandom_range(99) < tx_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= r.op;
    req_ch.task_handle   <= r.handle;
    req_ch.first_delay   <= r.delay;
    req_ch.repeat_period <= r.period;
    req_ch.slot_index    <= r.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Sender goes quiet until every owed reply has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  // Reply side: random stalls, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    sched_req_t r;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_TICK;
    req_ch.task_handle   = '0;
    req_ch.first_delay   = '0;
    req_ch.repeat_period = '0;
    req_ch.slot_index    = '0;
    hold_req = 1'b0;
    tx_idle  = 38;
    rx_idle  = 59;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dispatch, fill to full with edge values, age, run, free, refill
    send(mk(OP_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    send(mk(OP_ADD, 8'h00, 16'd0, 16'd0, 3'd7));
    send(mk(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0));
    send(mk(OP_ADD, 8'h5A, 16'd1, 16'd1, 3'd0));
    send(mk(OP_ADD, 8'hA5, 16'd0, 16'd2, 3'd0));
    send(mk(OP_ADD, 8'h11, 16'd2, 16'd0, 3'd0));
    send(mk(OP_ADD, 8'h22, 16'd0, 16'd3, 3'd0));
    send(mk(OP_ADD, 8'h33, 16'd0, 16'd1, 3'd0));
    send(mk(OP_ADD, 8'h44, 16'd1, 16'd0, 3'd0));
    send(mk(OP_ADD, 8'h99, 16'd0, 16'd0, 3'd0));
    send(mk(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    send(mk(OP_TICK, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_TICK, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DELETE, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd1));
    send(mk(OP_DELETE, 8'h00, 16'd0, 16'd0, 3'd7));
    send(mk(OP_ADD, 8'h77, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_TICK, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'h00, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'h00, 16'd0, 16'd0, 3'd0));
    drain();

    // pending count saturation on a periodic and a one-shot slot
    for (int i = 0; i < TASKS; i++)
      send(mk(OP_DELETE, 8'($urandom), 16'($urandom), 16'($urandom), 3'(i)));
    send(mk(OP_ADD, 8'hC3, 16'd0, 16'd1, 3'd0));
    send(mk(OP_ADD, 8'h3C, 16'd0, 16'd0, 3'd0));
    repeat (260) send(mk(OP_TICK, 8'd0, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0));
    send(mk(OP_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0));
    drain();

    repeat (60) send(rand_req());
    drain();

    tx_idle = 59;
    rx_idle = 38;
    repeat (60) send(rand_req());
    drain();

    // long reply stall while requests keep coming, so the table backs up
    tx_idle = 0;
    rx_idle = 0;
    hold_req <= 1'b1;
    repeat (24) begin
      r = rand_req();
      if (r.op == OP_TICK) r.op = OP_DISPATCH;
      send(r);
    end
    drain();
    repeat (45) send(rand_req());
    drain();

    repeat (3 * TASKS) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ttst_pkg.sv
hdl/ttst_if.sv
hdl/ttst_cell.sv
hdl/ttst_head.sv
hdl/tick_task_scheduler_table.sv
tb/ttst_reply_checker.sv
tb/testbench.sv
